// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants and types of the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int PRIO_BITS_DEF   = 8;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int KIND_BITS       = 8;
    localparam int STATUS_BITS     = 2;

    // request operation codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // response status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // per-cycle command to every cell of the row
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== rtl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq request and response channels
// valid/ready channels carrying the queue request and its response
// ----------------------------------------------------------------------------
interface spq_req_if #(
    parameter int PRIO_BITS   = spq_pkg::PRIO_BITS_DEF,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [PRIO_BITS-1:0]           priority_req;
    logic [HANDLE_BITS-1:0]         payload_handle;
    logic [spq_pkg::KIND_BITS-1:0]  data_kind;

    modport source (output valid, cmd, priority_req, payload_handle, data_kind,
                    input ready);
    modport sink   (input valid, cmd, priority_req, payload_handle, data_kind,
                    output ready);
endinterface

interface spq_rsp_if #(
    parameter int PRIO_BITS   = spq_pkg::PRIO_BITS_DEF,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF,
    parameter int OCC_BITS    = $clog2(spq_pkg::CAPACITY_DEF + 1)
);
    logic                            valid;
    logic                            ready;
    logic [spq_pkg::STATUS_BITS-1:0] status;
    logic [PRIO_BITS-1:0]            out_priority;
    logic [HANDLE_BITS-1:0]          out_handle;
    logic [spq_pkg::KIND_BITS-1:0]   out_kind;
    logic [OCC_BITS-1:0]             occupancy;
    logic [HANDLE_BITS-1:0]          head_handle;

    modport source (output valid, status, out_priority, out_handle, out_kind,
                    occupancy, head_handle, input ready);
    modport sink   (input valid, status, out_priority, out_handle, out_kind,
                    occupancy, head_handle, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: holds a record and trades it with its neighbors
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIO_BITS   = spq_pkg::PRIO_BITS_DEF,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spq_pkg::cell_ctrl_t           ctrl,
    input  logic [PRIO_BITS-1:0]          new_prio,
    input  logic [HANDLE_BITS-1:0]        new_handle,
    input  logic [spq_pkg::KIND_BITS-1:0] new_kind,
    input  logic                          left_valid,
    input  logic                          left_shift,
    input  logic [PRIO_BITS-1:0]          left_prio,
    input  logic [HANDLE_BITS-1:0]        left_handle,
    input  logic [spq_pkg::KIND_BITS-1:0] left_kind,
    input  logic                          right_valid,
    input  logic [PRIO_BITS-1:0]          right_prio,
    input  logic [HANDLE_BITS-1:0]        right_handle,
    input  logic [spq_pkg::KIND_BITS-1:0] right_kind,
    output logic                          valid,
    output logic                          shift,
    output logic [PRIO_BITS-1:0]          prio,
    output logic [HANDLE_BITS-1:0]        handle,
    output logic [spq_pkg::KIND_BITS-1:0] kind
);

    logic                          valid_reg, valid_next;
    logic [PRIO_BITS-1:0]          prio_reg, prio_next;
    logic [HANDLE_BITS-1:0]        handle_reg, handle_next;
    logic [spq_pkg::KIND_BITS-1:0] kind_reg, kind_next;

    // held record moves one slot back when the new one sorts strictly before it
    assign shift = valid_reg && (prio_reg > new_prio);

    always_comb
    begin
        valid_next  = valid_reg;
        prio_next   = prio_reg;
        handle_next = handle_reg;
        kind_next   = kind_reg;
        if (ctrl.push)
        begin
            priority if (left_shift)
            begin
                valid_next  = 1'b1;
                prio_next   = left_prio;
                handle_next = left_handle;
                kind_next   = left_kind;
            end
            else if ((shift || !valid_reg) && left_valid)
            begin
                valid_next  = 1'b1;
                prio_next   = new_prio;
                handle_next = new_handle;
                kind_next   = new_kind;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next  = right_valid;
            prio_next   = right_prio;
            handle_next = right_handle;
            kind_next   = right_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg   <= prio_next;
        handle_reg <= handle_next;
        kind_reg   <= kind_next;
    end

    assign valid  = valid_reg;
    assign prio   = prio_reg;
    assign handle = handle_reg;
    assign kind   = kind_reg;

endmodule

// ===== rtl/stable_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// bounded sorted priority queue, lower priority first, ties in arrival order
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                                         | accepted when
//  --------+-----+------------------------------------------------+-----------------------
//  req     | in  | cmd, priority_req, payload_handle, data_kind   | req.valid && req.ready
//  rsp     | out | status, out_priority, out_handle, out_kind,    | rsp.valid && rsp.ready
//          |     | occupancy, head_handle                         |
//
//  one request per cycle while req.ready is high; its response shows in the response
//  register in the cycle after acceptance, and the cell row updates in the accepting cycle
//  reset clears the cell valid flags, the fill count and the response valid flag;
//  there is no clearing pass, the queue is usable right after reset
//  req.ready drops only while a response waits and rsp.ready is low
//
module stable_priority_queue_core #(
    parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
    parameter int PRIO_BITS   = spq_pkg::PRIO_BITS_DEF,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
    input logic     clk,
    input logic     rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int OCC_BITS = $clog2(CAPACITY + 1);

    // cell row taps
    logic                          cell_valid  [CAPACITY];
    logic                          cell_shift  [CAPACITY];
    logic [PRIO_BITS-1:0]          cell_prio   [CAPACITY];
    logic [HANDLE_BITS-1:0]        cell_handle [CAPACITY];
    logic [spq_pkg::KIND_BITS-1:0] cell_kind   [CAPACITY];

    spq_pkg::cell_ctrl_t ctrl;

    logic accept;
    logic full;
    logic empty;
    logic is_push;
    logic is_pop;

    logic [OCC_BITS-1:0] count_reg, count_next;

    // response register
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [spq_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [PRIO_BITS-1:0]            out_prio_reg, out_prio_next;
    logic [HANDLE_BITS-1:0]          out_handle_reg, out_handle_next;
    logic [spq_pkg::KIND_BITS-1:0]   out_kind_reg, out_kind_next;
    logic [OCC_BITS-1:0]             occ_reg, occ_next;
    logic [HANDLE_BITS-1:0]          head_reg, head_next;

    // accept whenever the response slot is free or drains this cycle
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // the row is contiguous from slot 0, so its ends give empty and full
    assign empty   = !cell_valid[0];
    assign full    = cell_valid[CAPACITY-1];
    assign is_push = (req.cmd == spq_pkg::CMD_PUSH);
    assign is_pop  = (req.cmd == spq_pkg::CMD_POP);

    assign ctrl.push = accept && is_push && !full;
    assign ctrl.pop  = accept && is_pop && !empty;

    // ---------------- cell row ----------------
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                          l_valid;
            logic                          l_shift;
            logic [PRIO_BITS-1:0]          l_prio;
            logic [HANDLE_BITS-1:0]        l_handle;
            logic [spq_pkg::KIND_BITS-1:0] l_kind;
            logic                          r_valid;
            logic [PRIO_BITS-1:0]          r_prio;
            logic [HANDLE_BITS-1:0]        r_handle;
            logic [spq_pkg::KIND_BITS-1:0] r_kind;

            if (gi == 0)
            begin : g_head
                // the head has no neighbor ahead: it behaves as if one stays put
                assign l_valid  = 1'b1;
                assign l_shift  = 1'b0;
                assign l_prio   = req.priority_req;
                assign l_handle = req.payload_handle;
                assign l_kind   = req.data_kind;
            end
            else
            begin : g_mid
                assign l_valid  = cell_valid[gi-1];
                assign l_shift  = cell_shift[gi-1];
                assign l_prio   = cell_prio[gi-1];
                assign l_handle = cell_handle[gi-1];
                assign l_kind   = cell_kind[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                // a pop empties the last slot
                assign r_valid  = 1'b0;
                assign r_prio   = '0;
                assign r_handle = '0;
                assign r_kind   = '0;
            end
            else
            begin : g_body
                assign r_valid  = cell_valid[gi+1];
                assign r_prio   = cell_prio[gi+1];
                assign r_handle = cell_handle[gi+1];
                assign r_kind   = cell_kind[gi+1];
            end

            spq_cell #(
                .PRIO_BITS   (PRIO_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .new_prio     (req.priority_req),
                .new_handle   (req.payload_handle),
                .new_kind     (req.data_kind),
                .left_valid   (l_valid),
                .left_shift   (l_shift),
                .left_prio    (l_prio),
                .left_handle  (l_handle),
                .left_kind    (l_kind),
                .right_valid  (r_valid),
                .right_prio   (r_prio),
                .right_handle (r_handle),
                .right_kind   (r_kind),
                .valid        (cell_valid[gi]),
                .shift        (cell_shift[gi]),
                .prio         (cell_prio[gi]),
                .handle       (cell_handle[gi]),
                .kind         (cell_kind[gi])
            );
        end
    endgenerate

    // ---------------- fill count ----------------
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + OCC_BITS'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - OCC_BITS'(1);
        end
    end

    // ---------------- response ----------------
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        status_next     = status_reg;
        out_prio_next   = out_prio_reg;
        out_handle_next = out_handle_reg;
        out_kind_next   = out_kind_reg;
        occ_next        = occ_reg;
        head_next       = head_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            rsp_valid_next  = 1'b1;
            status_next     = spq_pkg::ST_OK;
            out_prio_next   = '0;
            out_handle_next = '0;
            out_kind_next   = '0;
            occ_next        = count_next;
            // head left unchanged by a refused request
            head_next       = cell_valid[0] ? cell_handle[0] : '0;

            priority if (is_push && full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else if (is_pop && empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else if (is_push)
            begin
                // new record becomes the head if the queue was empty or it sorts first
                if (!cell_valid[0] || cell_shift[0])
                begin
                    head_next = req.payload_handle;
                end
            end
            else
            begin
                out_prio_next   = cell_prio[0];
                out_handle_next = cell_handle[0];
                out_kind_next   = cell_kind[0];
                head_next       = cell_valid[1] ? cell_handle[1] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        out_prio_reg   <= out_prio_next;
        out_handle_reg <= out_handle_next;
        out_kind_reg   <= out_kind_next;
        occ_reg        <= occ_next;
        head_reg       <= head_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.out_handle   = out_handle_reg;
    assign rsp.out_kind     = out_kind_reg;
    assign rsp.occupancy    = occ_reg;
    assign rsp.head_handle  = head_reg;

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks on the queue responses, bound to the top level
// ----------------------------------------------------------------------------
module spq_checker #(
    parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF,
    parameter int OCC_BITS    = $clog2(spq_pkg::CAPACITY_DEF + 1)
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [spq_pkg::STATUS_BITS-1:0] status,
    input logic [OCC_BITS-1:0]             occupancy,
    input logic [HANDLE_BITS-1:0]          head_handle
);

    // a response waiting for the sink stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == spq_pkg::ST_EMPTY) |-> (occupancy == '0))
        else $error("empty status with records held");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == spq_pkg::ST_FULL) |-> (occupancy == OCC_BITS'(CAPACITY)))
        else $error("full status below capacity");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (occupancy == '0) |-> (head_handle == '0))
        else $error("head handle on empty queue");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (occupancy <= OCC_BITS'(CAPACITY)))
        else $error("occupancy above capacity");

endmodule

bind stable_priority_queue_core spq_checker #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS),
    .OCC_BITS    (OCC_BITS)
) u_spq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .occupancy   (rsp.occupancy),
    .head_handle (rsp.head_handle)
);
